FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the breathing ramp generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/lbrg_pkg.sv
// Types and constants of the LED breathing ramp generator.
package lbrg_pkg;

    localparam int DEF_CHANNELS   = 4;
    localparam int LEVEL_W        = 8;
    localparam int CHAN_FIELD_W   = 2;
    localparam int MASK_W         = 4;
    localparam int IN_TDATA_W     = 48;
    localparam int OUT_TDATA_W    = 24;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 8;

    localparam logic [LEVEL_W-1:0] FULL_SCALE_RESET = 8'd100;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LOW_MASK = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE      = 1'd1;

    // item operations
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // pin drive codes
    localparam logic [1:0] PIN_LOW  = 2'd0;
    localparam logic [1:0] PIN_HIGH = 2'd1;
    localparam logic [1:0] PIN_PWM  = 2'd2;

    // one channel entry of the state memory
    typedef struct packed {
        logic [LEVEL_W-1:0] low_bound;
        logic [LEVEL_W-1:0] high_bound;
        logic [LEVEL_W-1:0] step_size;
        logic [LEVEL_W-1:0] delay_reload;
        logic [LEVEL_W-1:0] turns_left;
        logic [LEVEL_W-1:0] current_level;
        logic               rising;
        logic [LEVEL_W-1:0] ticks_left;
        logic               running;
    } chan_state_t;

    typedef struct packed {
        logic                    operation;
        logic [CHAN_FIELD_W-1:0] channel;
        logic [LEVEL_W-1:0]      ramp_min;
        logic [LEVEL_W-1:0]      ramp_max;
        logic [LEVEL_W-1:0]      ramp_step;
        logic [LEVEL_W-1:0]      tick_delay;
        logic [LEVEL_W-1:0]      repeat_count;
    } item_t;

endpackage

FILE: sv/led_breathing_ramp_generator_top.sv
// LED breathing ramp generator: per-channel triangle ramps kept in one state memory.
// Each input beat takes two steps: the accept edge reads the channel entry from the
// state memory into a register, and the ST_CALC edge computes the ramp step, writes the entry
// back and loads the output register. The output register frees the input side, so a new
// beat is taken while a result waits; the compute cycle stalls only while the output
// register still holds an untaken result. Entries read as zero until first written.
module led_breathing_ramp_generator_top #(
    parameter int CHANNELS = lbrg_pkg::DEF_CHANNELS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // channel[1:0], ramp_min[9:2], ramp_max[17:10], ramp_step[25:18],
    // tick_delay[33:26], repeat_count[41:34], zero fill
    input  logic [lbrg_pkg::IN_TDATA_W-1:0]    s_tdata,
    // operation
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // out_channel[1:0], level[9:2], duty[17:10], pin_mode[19:18], updated[20],
    // complete[21], zero fill
    output logic [lbrg_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lbrg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lbrg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lbrg_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

    typedef enum logic {ST_IDLE, ST_CALC} state_t;

    state_t                  state_reg, state_next;
    item_t                   item_reg, item_next;
    logic [MASK_W-1:0]       active_low_mask_reg;
    logic [LEVEL_W-1:0]      full_scale_reg;
    logic [CHANNELS-1:0]     valid_reg;
    logic                    rd_valid_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    chan_state_t             mem [CHANNELS];
    chan_state_t             rd_entry_reg;

    logic                    in_fire;
    logic                    calc_fire;
    logic [CH_W-1:0]         rd_idx;
    logic [CH_W-1:0]         wr_idx;
    logic                    chan_ok;

    chan_state_t             cur;
    chan_state_t             nxt;
    logic [LEVEL_W-1:0]      lvl;
    logic [LEVEL_W-1:0]      stepped;
    logic [LEVEL_W-1:0]      v;
    logic [LEVEL_W-1:0]      duty;
    logic [1:0]              pin_mode;
    logic                    upd;
    logic                    done;
    logic                    turn;
    logic                    start_ok;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_fire   = s_tvalid && s_tready;
    assign calc_fire = (state_reg == ST_CALC) && (!m_tvalid_reg || m_tready);
    assign rd_idx    = CH_W'(s_tdata[CHAN_FIELD_W-1:0]);
    assign wr_idx    = CH_W'(item_reg.channel);
    assign chan_ok   = {3'b000, item_reg.channel} < CH_LIMIT;

    always_comb begin
        item_next.operation    = s_tuser;
        item_next.channel      = s_tdata[1:0];
        item_next.ramp_min     = s_tdata[9:2];
        item_next.ramp_max     = s_tdata[17:10];
        item_next.ramp_step    = s_tdata[25:18];
        item_next.tick_delay   = s_tdata[33:26];
        item_next.repeat_count = s_tdata[41:34];
    end

    // ramp update for the addressed channel
    always_comb begin
        cur      = rd_valid_reg ? rd_entry_reg : '0;
        nxt      = cur;
        lvl      = cur.current_level;
        stepped  = '0;
        upd      = 1'b0;
        done     = 1'b1;
        turn     = 1'b0;
        start_ok = (item_reg.ramp_min < item_reg.ramp_max) && (item_reg.ramp_step != '0)
                   && (item_reg.tick_delay != '0);
        if (item_reg.operation == OP_START) begin
            lvl               = item_reg.ramp_min;
            upd               = 1'b1;
            done              = !start_ok;
            nxt.current_level = item_reg.ramp_min;
            nxt.running       = start_ok;
            nxt.low_bound     = item_reg.ramp_min;
            if (start_ok) begin
                nxt.rising       = 1'b1;
                nxt.high_bound   = item_reg.ramp_max;
                nxt.step_size    = item_reg.ramp_step;
                nxt.delay_reload = item_reg.tick_delay;
                nxt.turns_left   = item_reg.repeat_count;
                nxt.ticks_left   = item_reg.tick_delay;
            end else begin
                nxt.high_bound   = item_reg.ramp_min;
                nxt.delay_reload = '0;
            end
        end else if (!cur.running) begin
            done = 1'b1;
        end else if (cur.ticks_left > 8'd1) begin
            nxt.ticks_left = cur.ticks_left - 8'd1;
            done           = 1'b0;
        end else begin
            upd  = 1'b1;
            done = 1'b0;
            if (cur.rising) begin
                stepped = cur.current_level + cur.step_size;
                lvl     = stepped;
                if (stepped > cur.high_bound) begin
                    lvl        = cur.high_bound - cur.step_size;
                    nxt.rising = 1'b0;
                    turn       = 1'b1;
                end
            end else begin
                stepped = cur.current_level - cur.step_size;
                lvl     = stepped;
                // a wrap below zero is caught only when it lands above the high bound
                if (stepped < cur.low_bound || stepped > cur.high_bound) begin
                    lvl        = cur.low_bound + cur.step_size;
                    nxt.rising = 1'b1;
                    turn       = 1'b1;
                end
            end
            if (turn && cur.turns_left != '0) begin
                nxt.turns_left = cur.turns_left - 8'd1;
                done           = (cur.turns_left == 8'd1);
            end
            if (done) begin
                lvl              = cur.low_bound;
                nxt.running      = 1'b0;
                nxt.delay_reload = '0;
                nxt.ticks_left   = '0;
            end else begin
                nxt.ticks_left = cur.delay_reload;
            end
            nxt.current_level = lvl;
        end

        // pin mapping
        v = active_low_mask_reg[item_reg.channel] ? (full_scale_reg - lvl) : lvl;
        if (v == '0) begin
            pin_mode = PIN_LOW;
            duty     = '0;
        end else if (v >= full_scale_reg) begin
            pin_mode = PIN_HIGH;
            duty     = full_scale_reg;
        end else begin
            pin_mode = PIN_PWM;
            duty     = v;
        end

        if (!chan_ok) begin
            lvl      = '0;
            duty     = '0;
            pin_mode = PIN_LOW;
            upd      = 1'b0;
            done     = 1'b1;
        end

        m_tdata_next = {2'b00, done, upd, pin_mode, duty, lvl, item_reg.channel};
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (calc_fire) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state memory: one read port at accept, one write port at writeback
    always_ff @(posedge aclk) begin
        if (calc_fire && chan_ok) begin
            mem[wr_idx] <= nxt;
        end
        if (in_fire) begin
            rd_entry_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            m_tvalid_reg        <= 1'b0;
            valid_reg           <= '0;
            rd_valid_reg        <= 1'b0;
            active_low_mask_reg <= '0;
            full_scale_reg      <= FULL_SCALE_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (in_fire) begin
                item_reg     <= item_next;
                rd_valid_reg <= valid_reg[rd_idx];
            end
            if (calc_fire) begin
                m_tdata_reg <= m_tdata_next;
                if (chan_ok) begin
                    valid_reg[wr_idx] <= 1'b1;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ACTIVE_LOW_MASK: active_low_mask_reg <= cfg_data[MASK_W-1:0];
                    REG_FULL_SCALE:      full_scale_reg      <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

`include "assert_macros.svh"

    `ASSERT_NEXT(a_two_cycle_item, aclk, aresetn, in_fire, !s_tready)
    `ASSERT_SAME(a_no_bad_mode, aclk, aresetn, m_tvalid, m_tdata[19:18] != 2'b11)
    `ASSERT_SAME(a_high_full, aclk, aresetn, m_tvalid && m_tdata[19:18] == PIN_HIGH,
                 m_tdata[17:10] == full_scale_reg)
    `ASSERT_SAME(a_pwm_range, aclk, aresetn, m_tvalid && m_tdata[19:18] == PIN_PWM,
                 m_tdata[17:10] != '0 && m_tdata[17:10] < full_scale_reg)

endmodule
